/* hw/rtl/rdb_pkg.sv */
`default_nettype none

package rdb_pkg;

  // Default width of the window sample counter.
  localparam int DEFAULT_COUNT_BITS = 16;

  // A squared 16-bit magnitude is at most 2^30.
  localparam int SQ_BITS = 31;

  // The full-scale square is 32768^2 = 2^30.
  localparam int FULL_SCALE_LOG2 = 30;

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Fraction bits of the fixed-point log2 values.
  localparam int FRAC_BITS = 32;

  // 100^2 * 4 in the percent test: (2p-1)^2 * n * 2^30 <= 40000 * sum.
  localparam logic [15:0] PCT_SCALE = 16'd40000;

  // 160 * log10(2) in Q.32.
  localparam int LOG_K_BITS = 38;
  localparam logic [LOG_K_BITS-1:0] LOG_K = 38'd206866237839;

  // dB magnitude floor, -96 dB in 1/16 dB.
  localparam logic [10:0] DB_FLOOR = 11'd1536;

  // Item codes.
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  // One queued item: its code and the squared sample magnitude.
  typedef struct packed {
    op_t               op;
    logic [SQ_BITS-1:0] sq;
  } rdb_entry_t;

  // Report sequencer states.
  typedef enum logic [2:0] {
    RPT_IDLE,
    RPT_SCALE,
    RPT_PCT,
    RPT_NORM,
    RPT_SQUARE,
    RPT_DIFF,
    RPT_MUL,
    RPT_DONE
  } rpt_state_t;

endpackage

`default_nettype wire

/* hw/rtl/rdb_if.sv */
`default_nettype none

// Input channel: one audio sample or one measurement tick per item.
interface rdb_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

// Result channel: one level report per tick.
interface rdb_out_if;
  logic               valid;
  logic               ready;
  logic [6:0]         level_percent;
  logic signed [11:0] level_db_sixteenths;
  logic [15:0]        window_samples;
  logic               window_saturated;

  modport source (output valid, output level_percent, output level_db_sixteenths,
                  output window_samples, output window_saturated, input ready);
  modport sink   (input valid, input level_percent, input level_db_sixteenths,
                  input window_samples, input window_saturated, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rms_dbfs_level_meter.sv */
`default_nettype none

// RMS level meter for signed 16-bit audio, reported in percent and dBFS.
// The input channel carries items with an operation code: a sample item adds
// the square of the sample to the window, a tick item reports and clears it.
// The output channel carries one report per tick: percent of full scale,
// level in 1/16 dBFS floored at -96 dB, sample count and saturation flag.
// Sample items are taken one per cycle while the queue has room; squaring is
// registered in the front stage, and the accumulator in the back end adds one
// square per cycle while no tick waits at the head of the queue. A tick passes
// through the front stage and the queue to the report sequencer. An empty or
// silent window skips the arithmetic. Otherwise the sequencer runs 16 shift-add
// steps, 100 percent steps, two normalizations, two 32-round log2 squarings,
// one sign check and, for a level below full scale, 64 steps of the dB product.
// Samples keep flowing into the cleared window while a report is computed; a
// second tick waits in the queue until the previous report has been taken.
// A stalled output holds its report; behind a later tick, in ready falls.
// Reset clears the window, the queue and the report state.
module rms_dbfs_level_meter #(
  parameter int COUNT_BITS = rdb_pkg::DEFAULT_COUNT_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rdb_in_if.sink    in_chan,
  rdb_out_if.source out_chan
);
  import rdb_pkg::*;

  localparam int SUM_BITS = COUNT_BITS + FULL_SCALE_LOG2;

  rdb_entry_t            push_entry;
  logic                  push_valid;
  logic                  push_ready;
  rdb_entry_t            pop_entry;
  logic                  pop_valid;
  logic                  pop_ready;
  logic                  rpt_busy;
  logic                  rpt_start;
  logic [SUM_BITS-1:0]   win_sum;
  logic [COUNT_BITS-1:0] win_count;
  logic                  win_sat;

  rdb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  rdb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  rdb_back #(
    .COUNT_BITS (COUNT_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .rpt_busy  (rpt_busy),
    .rpt_start (rpt_start),
    .win_sum   (win_sum),
    .win_count (win_count),
    .win_sat   (win_sat)
  );

  rdb_report #(
    .COUNT_BITS (COUNT_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rpt_start),
    .win_sum   (win_sum),
    .win_count (win_count),
    .win_sat   (win_sat),
    .busy      (rpt_busy),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

/* hw/rtl/rdb_front.sv */
`default_nettype none

module rdb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rdb_in_if.sink                 in_chan,
  output rdb_pkg::rdb_entry_t    push_entry,
  output logic                   push_valid,
  input  wire logic              push_ready
);
  import rdb_pkg::*;

  logic       stage_valid_r;
  logic       stage_valid_nxt;
  rdb_entry_t stage_r;
  logic       accept;
  logic [16:0] mag;
  logic [33:0] sq_full;

  // The stage takes a new item whenever it is empty or drains this cycle.
  assign in_chan.ready = !stage_valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Magnitude of the sample; the most negative code gives 32768.
  always_comb begin
    if (in_chan.sample[15]) begin
      mag = 17'd0 - {1'b1, in_chan.sample};
    end else begin
      mag = {1'b0, in_chan.sample};
    end
    sq_full = mag * mag;
  end

  always_comb begin
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (push_ready) begin
      stage_valid_nxt = 1'b0;
    end else begin
      stage_valid_nxt = stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  // Registered classification and square of the accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r.op <= op_t'(in_chan.operation);
      stage_r.sq <= sq_full[SQ_BITS-1:0];
    end
  end

  assign push_valid = stage_valid_r;
  assign push_entry = stage_r;

endmodule

`default_nettype wire

/* hw/rtl/rdb_queue.sv */
`default_nettype none

module rdb_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire rdb_pkg::rdb_entry_t push_entry,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output rdb_pkg::rdb_entry_t      pop_entry
);
  import rdb_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  rdb_entry_t          entries_r [QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr_r;
  logic [PW-1:0]       rd_ptr_r;
  logic [PW:0]         fill_r;
  logic [PW:0]         fill_nxt;
  logic                push;
  logic                pop;

  assign push_ready = (fill_r != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = entries_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  // Pointers wrap at the power-of-two depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rdb_back.sv */
`default_nettype none

module rdb_back #(
  parameter int COUNT_BITS = rdb_pkg::DEFAULT_COUNT_BITS,
  parameter int SUM_BITS   = COUNT_BITS + rdb_pkg::FULL_SCALE_LOG2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                pop_valid,
  output logic                     pop_ready,
  input  wire rdb_pkg::rdb_entry_t pop_entry,
  input  wire logic                rpt_busy,
  output logic                     rpt_start,
  output logic [SUM_BITS-1:0]      win_sum,
  output logic [COUNT_BITS-1:0]    win_count,
  output logic                     win_sat
);
  import rdb_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [SUM_BITS-1:0]   sum_r;
  logic [SUM_BITS-1:0]   sum_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  sat_r;
  logic                  sat_nxt;
  logic                  pop;

  // Samples always flow; a tick waits until the report unit is free.
  assign pop_ready = (pop_entry.op == OP_SAMPLE) || !rpt_busy;
  assign pop       = pop_valid && pop_ready;
  assign rpt_start = pop && (pop_entry.op == OP_TICK);

  // The report unit captures the window as it stands before the clear.
  assign win_sum   = sum_r;
  assign win_count = count_r;
  assign win_sat   = sat_r;

  // Accumulate a sample, drop it at the full count, or clear on a tick.
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    sat_nxt   = sat_r;
    if (pop) begin
      if (pop_entry.op == OP_TICK) begin
        sum_nxt   = '0;
        count_nxt = '0;
        sat_nxt   = 1'b0;
      end else if (count_r == COUNT_MAX) begin
        sat_nxt = 1'b1;
      end else begin
        sum_nxt   = sum_r + SUM_BITS'(pop_entry.sq);
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      sat_r   <= 1'b0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rdb_report.sv */
`default_nettype none

module rdb_report #(
  parameter int COUNT_BITS = rdb_pkg::DEFAULT_COUNT_BITS,
  parameter int SUM_BITS   = COUNT_BITS + rdb_pkg::FULL_SCALE_LOG2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [SUM_BITS-1:0]   win_sum,
  input  wire logic [COUNT_BITS-1:0] win_count,
  input  wire logic                  win_sat,
  output logic                       busy,
  rdb_out_if.source                  out_chan
);
  import rdb_pkg::*;

  localparam int EW = $clog2(SUM_BITS);
  localparam int LQ = EW + FRAC_BITS;
  localparam int LW = LQ + 2;
  localparam int RW = SUM_BITS + 16;
  localparam int AW = COUNT_BITS + 16;
  localparam logic [LW-1:0] LOG_OFFSET = LW'(FULL_SCALE_LOG2) << FRAC_BITS;
  localparam logic [EW-1:0] E_TOP      = EW'(SUM_BITS - 1);
  localparam logic [6:0]    SCALE_FIRST = 7'd15;
  localparam logic [6:0]    PCT_LAST    = 7'd100;
  localparam logic [6:0]    SQUARE_LAST = 7'd31;
  localparam logic [6:0]    MUL_LAST    = 7'd63;

  rpt_state_t            state_r;
  rpt_state_t            state_nxt;
  logic [6:0]            step_r;
  logic [SUM_BITS-1:0]   sum_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  sat_r;
  logic [RW-1:0]         r_r;
  logic [AW-1:0]         a_r;
  logic [AW-1:0]         b_r;
  logic [6:0]            pct_r;
  logic [SUM_BITS-1:0]   sh_r;
  logic [EW-1:0]         e_r;
  logic [31:0]           m_r;
  logic [31:0]           frac_r;
  logic                  pass_r;
  logic [LQ-1:0]         lsum_r;
  logic [LQ-1:0]         lcnt_r;
  logic [LW-1:0]         mq_r;
  logic [LOG_K_BITS-1:0] acc_r;
  logic                  sticky_r;
  logic [10:0]           dbmag_r;

  logic                  trivial;
  logic [RW-1:0]         r_nxt;
  logic [AW-1:0]         cnt8;
  logic [AW-1:0]         rq;
  logic [63:0]           prod;
  logic [32:0]           prod_hi;
  logic [31:0]           m_nxt;
  logic [31:0]           frac_nxt;
  logic [LW-1:0]         diff;
  logic [LOG_K_BITS:0]   mac;
  logic [LOG_K_BITS:0]   fin;
  logic [10:0]           fin_cap;

  // An empty or silent window skips the arithmetic and reports the floor.
  assign trivial = (win_count == '0) || (win_sum == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RPT_IDLE: begin
        if (start) begin
          state_nxt = trivial ? RPT_DONE : RPT_SCALE;
        end
      end
      RPT_SCALE: begin
        if (step_r == '0) begin
          state_nxt = RPT_PCT;
        end
      end
      RPT_PCT: begin
        if (step_r == PCT_LAST) begin
          state_nxt = RPT_NORM;
        end
      end
      RPT_NORM: begin
        if (sh_r[SUM_BITS-1]) begin
          state_nxt = RPT_SQUARE;
        end
      end
      RPT_SQUARE: begin
        if (step_r == SQUARE_LAST) begin
          state_nxt = pass_r ? RPT_DIFF : RPT_NORM;
        end
      end
      RPT_DIFF: begin
        state_nxt = diff[LW-1] ? RPT_MUL : RPT_DONE;
      end
      RPT_MUL: begin
        if (step_r == MUL_LAST) begin
          state_nxt = RPT_DONE;
        end
      end
      RPT_DONE: begin
        if (out_chan.ready) begin
          state_nxt = RPT_IDLE;
        end
      end
      default: state_nxt = RPT_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy                         = (state_r != RPT_IDLE);
    out_chan.valid               = (state_r == RPT_DONE);
    out_chan.level_percent       = pct_r;
    out_chan.level_db_sixteenths = 12'd0 - {1'b0, dbmag_r};
    out_chan.window_samples      = 16'(cnt_r);
    out_chan.window_saturated    = sat_r;
  end

  // Datapath of each step.
  always_comb begin
    // 40000 * sum by shift and add, most significant multiplier bit first.
    r_nxt = {r_r[RW-2:0], 1'b0} + (PCT_SCALE[step_r[3:0]] ? RW'(sum_r) : RW'(0));
    cnt8  = AW'({cnt_r, 3'b000});
    rq    = r_r[RW-1:FULL_SCALE_LOG2];
    // One squaring round of the log2 mantissa.
    prod    = m_r * m_r;
    prod_hi = prod[63:31];
    if (prod_hi[32]) begin
      m_nxt    = prod_hi[32:1];
      frac_nxt = {frac_r[30:0], 1'b1};
    end else begin
      m_nxt    = prod_hi[31:0];
      frac_nxt = {frac_r[30:0], 1'b0};
    end
    diff = {2'b00, lsum_r} - {2'b00, lcnt_r} - LOG_OFFSET;
    // One bit of the dB product, low bits shifted out into the fraction.
    mac = {1'b0, acc_r} + (mq_r[0] ? {1'b0, LOG_K} : '0);
    fin = {1'b0, mac[LOG_K_BITS:1]} + (LOG_K_BITS+1)'(mac[0] && sticky_r);
    if (fin > (LOG_K_BITS+1)'(DB_FLOOR)) begin
      fin_cap = DB_FLOOR;
    end else begin
      fin_cap = fin[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RPT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      RPT_IDLE: begin
        if (start) begin
          sum_r   <= win_sum;
          cnt_r   <= win_count;
          sat_r   <= win_sat;
          pct_r   <= '0;
          dbmag_r <= DB_FLOOR;
          r_r     <= '0;
          step_r  <= SCALE_FIRST;
        end
      end
      RPT_SCALE: begin
        r_r    <= r_nxt;
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          a_r    <= AW'(cnt_r);
          b_r    <= cnt8;
          step_r <= 7'd1;
        end
      end
      RPT_PCT: begin
        // a holds (2p-1)^2 * n and b holds 8p * n.
        if (a_r <= rq) begin
          pct_r <= pct_r + 1'b1;
        end
        a_r    <= a_r + b_r;
        b_r    <= b_r + cnt8;
        step_r <= step_r + 1'b1;
        if (step_r == PCT_LAST) begin
          sh_r   <= sum_r;
          e_r    <= E_TOP;
          pass_r <= 1'b0;
        end
      end
      RPT_NORM: begin
        if (sh_r[SUM_BITS-1]) begin
          m_r    <= sh_r[SUM_BITS-1 -: 32];
          frac_r <= '0;
          step_r <= '0;
        end else begin
          sh_r <= {sh_r[SUM_BITS-2:0], 1'b0};
          e_r  <= e_r - 1'b1;
        end
      end
      RPT_SQUARE: begin
        m_r    <= m_nxt;
        frac_r <= frac_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == SQUARE_LAST) begin
          if (pass_r) begin
            lcnt_r <= {e_r, frac_nxt};
          end else begin
            lsum_r <= {e_r, frac_nxt};
            sh_r   <= SUM_BITS'(cnt_r);
            e_r    <= E_TOP;
            pass_r <= 1'b1;
          end
        end
      end
      RPT_DIFF: begin
        if (diff[LW-1]) begin
          mq_r     <= LW'(0) - diff;
          acc_r    <= '0;
          sticky_r <= 1'b0;
          step_r   <= '0;
        end else begin
          dbmag_r <= '0;
        end
      end
      RPT_MUL: begin
        acc_r  <= mac[LOG_K_BITS:1];
        mq_r   <= {1'b0, mq_r[LW-1:1]};
        step_r <= step_r + 1'b1;
        if (step_r == MUL_LAST) begin
          dbmag_r <= fin_cap;
        end else begin
          sticky_r <= sticky_r | mac[0];
        end
      end
      RPT_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
